// ----- sv/esc_tg_pkg.sv -----
`timescale 1ns / 1ps

package esc_tg_pkg;

    // Field widths
    localparam int TIME_BITS = 32;
    localparam int NOW_W     = 32;
    localparam int THR_W     = 12;
    localparam int INT_W     = 16;
    localparam int CMD_W     = 11;
    localparam int CFG_W     = 16;

    // Shared divider: dividend wide enough for the speed scale
    localparam int DIV_W     = 20;
    localparam int DVSR_W    = 16;
    localparam int CNT_W     = $clog2(DIV_W);
    localparam int SPD_W     = 13;

    // Limit mapping constants
    localparam int FULL_LIMIT     = 1024;
    localparam int LOW_LIMIT      = 100;
    localparam int INTERVAL_START = 200;
    localparam int SPEED_HIGH     = 5000;
    localparam int SPEED_LOW      = 333;
    localparam int SPEED_SCALE    = 1000000;
    localparam int MAP_SPAN       = FULL_LIMIT - LOW_LIMIT;
    localparam int MAP_DIV        = SPEED_HIGH - SPEED_LOW;

    // Limit drop diff * MAP_SPAN / MAP_DIV as a reciprocal multiply; the
    // rounded-up reciprocal gives the truncated quotient over the whole band
    localparam int MAP_SHIFT = 25;
    localparam int RECIP_W   = 23;
    localparam int PROD_W    = SPD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] MAP_RECIP = RECIP_W'(
        ((64'(MAP_SPAN) << MAP_SHIFT) + 64'(MAP_DIV) - 64'd1) / 64'(MAP_DIV));

    // Register map
    localparam logic REG_LOSE    = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;
    localparam logic [CFG_W-1:0] LOSE_RESET    = CFG_W'(500);
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = CFG_W'(3000);

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic             rst;
        logic [CMD_W-1:0] cmd;
        logic             valid;
    } t_res;

    // Clamp a non-negative throttle to a limit
    function automatic logic [CMD_W-1:0] f_clamp_cmd(input logic [CMD_W-1:0] thr,
                                                     input logic [CMD_W-1:0] limit);
        f_clamp_cmd = (thr > limit) ? limit : thr;
    endfunction

    // Clamp speed to its band and return the distance below the top speed
    function automatic logic [SPD_W-1:0] f_speed_diff(input logic [DIV_W-1:0] speed);
        logic [DIV_W-1:0] s;
        s = speed;
        if (s < DIV_W'(SPEED_LOW)) begin
            s = DIV_W'(SPEED_LOW);
        end
        if (s > DIV_W'(SPEED_HIGH)) begin
            s = DIV_W'(SPEED_HIGH);
        end
        f_speed_diff = SPD_W'(DIV_W'(SPEED_HIGH) - s);
    endfunction

endpackage

// ----- sv/esc_tg_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module esc_tg_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  esc_tg_pkg::t_div_req i_req,
    output esc_tg_pkg::t_div_rsp o_rsp
);

    logic                              r_busy;
    logic                              r_done;
    logic [esc_tg_pkg::CNT_W-1:0]      r_cnt;
    logic [esc_tg_pkg::DIV_W-1:0]      r_quot;
    logic [esc_tg_pkg::DVSR_W-1:0]     r_rem;
    logic [esc_tg_pkg::DVSR_W-1:0]     r_dvsr;
    logic [esc_tg_pkg::DVSR_W:0]       trial;
    logic                              qbit;

    always_comb begin
        trial = {r_rem, r_quot[esc_tg_pkg::DIV_W-1]};
        qbit  = (trial >= {1'b0, r_dvsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= esc_tg_pkg::CNT_W'(esc_tg_pkg::DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_dvsr <= i_req.divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[esc_tg_pkg::DIV_W-2:0], qbit};
            r_rem  <= qbit ? esc_tg_pkg::DVSR_W'(trial - {1'b0, r_dvsr})
                           : esc_tg_pkg::DVSR_W'(trial);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ----- sv/esc_tg_ctrl.sv -----
`timescale 1ns / 1ps

// Sequencer: evaluates one event, driving the shared divider once for a
// speed-limited capture and mapping the speed to a limit by a reciprocal
// multiply.
module esc_tg_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_kind,
    input  logic [esc_tg_pkg::THR_W-1:0]      i_thr,
    input  logic [esc_tg_pkg::INT_W-1:0]      i_interval,
    input  logic [esc_tg_pkg::NOW_W-1:0]      i_now,
    input  logic [esc_tg_pkg::CFG_W-1:0]      i_lose,
    input  logic [esc_tg_pkg::CFG_W-1:0]      i_timeout,
    input  logic                              i_slot_free,
    input  esc_tg_pkg::t_div_rsp              i_div,
    output esc_tg_pkg::t_div_req              o_div,
    output logic                              o_idle,
    output logic                              o_push,
    output esc_tg_pkg::t_res                  o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_MAP  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]                          r_state, n_state;
    logic                                r_kind;
    logic [esc_tg_pkg::THR_W-1:0]        r_thr;
    logic [esc_tg_pkg::INT_W-1:0]        r_interval;
    logic [esc_tg_pkg::TIME_BITS-1:0]    r_now;
    logic [esc_tg_pkg::TIME_BITS-1:0]    r_last;
    logic [esc_tg_pkg::SPD_W-1:0]        r_diff, n_diff;
    logic [esc_tg_pkg::CMD_W-1:0]        r_map, n_map;
    esc_tg_pkg::t_res                    r_res, n_res;
    logic [esc_tg_pkg::TIME_BITS-1:0]    elapsed;
    logic [esc_tg_pkg::PROD_W-1:0]       map_prod;
    logic [esc_tg_pkg::CMD_W-1:0]        limit;
    logic                                lost;

    always_comb begin
        n_state  = r_state;
        n_res    = r_res;
        n_diff   = r_diff;
        n_map    = r_map;
        o_div    = '0;
        elapsed  = r_now - r_last;
        lost     = elapsed > esc_tg_pkg::TIME_BITS'(i_lose);
        map_prod = esc_tg_pkg::PROD_W'(r_diff) * esc_tg_pkg::PROD_W'(esc_tg_pkg::MAP_RECIP);
        limit    = esc_tg_pkg::CMD_W'(esc_tg_pkg::FULL_LIMIT) - r_map;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_kind) begin
                    n_res.valid = lost;
                    n_res.cmd   = '0;
                    n_res.rst   = lost && (elapsed > esc_tg_pkg::TIME_BITS'(i_timeout));
                    n_state     = S_DONE;
                end else if (r_thr[esc_tg_pkg::THR_W-1]) begin
                    n_res   = '{rst: 1'b0, cmd: '0, valid: 1'b1};
                    n_state = S_DONE;
                end else if (r_interval <= esc_tg_pkg::INT_W'(esc_tg_pkg::INTERVAL_START)) begin
                    n_res.valid = 1'b1;
                    n_res.rst   = 1'b0;
                    n_res.cmd   = esc_tg_pkg::f_clamp_cmd(
                                      r_thr[esc_tg_pkg::CMD_W-1:0],
                                      esc_tg_pkg::CMD_W'(esc_tg_pkg::FULL_LIMIT));
                    n_state     = S_DONE;
                end else begin
                    // speed = scale / interval
                    o_div.start    = 1'b1;
                    o_div.dividend = esc_tg_pkg::DIV_W'(esc_tg_pkg::SPEED_SCALE);
                    o_div.divisor  = r_interval;
                    n_state        = S_DIV1;
                end
            end
            S_DIV1: begin
                if (i_div.done) begin
                    n_diff  = esc_tg_pkg::f_speed_diff(i_div.quot);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // limit drop: high bits of diff times the scaled reciprocal
                n_map   = map_prod[esc_tg_pkg::MAP_SHIFT +: esc_tg_pkg::CMD_W];
                n_state = S_MAP;
            end
            S_MAP: begin
                n_res.valid = 1'b1;
                n_res.rst   = 1'b0;
                n_res.cmd   = esc_tg_pkg::f_clamp_cmd(r_thr[esc_tg_pkg::CMD_W-1:0], limit);
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            if (i_start && !i_kind) begin
                r_last <= esc_tg_pkg::TIME_BITS'(i_now);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_diff <= n_diff;
        r_map  <= n_map;
        if (i_start) begin
            r_kind     <= i_kind;
            r_thr      <= i_thr;
            r_interval <= i_interval;
            r_now      <= esc_tg_pkg::TIME_BITS'(i_now);
        end
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_push = (r_state == S_DONE) && i_slot_free;
    assign o_res  = r_res;

endmodule

// ----- sv/esc_throttle_guard_top.sv -----
`timescale 1ns / 1ps

// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+--------------------------------------------
// s_ stream | in        | s_tvalid / s_tready   | tuser: kind; tdata: throttle_in, interval, now
// m_ stream | out       | m_tvalid / m_tready   | tdata: valid, cmd, reset_request
// APB       | in/out    | psel, penable, pready | lose_time_ms @0x0, timeout_ms @0x4
//
// One beat at a time. A commutation beat, a capture with a negative throttle
// or a short interval passes the evaluate state and then the done state, from
// which the result is loaded into the output register. A speed-limited capture
// runs the shared 20-step restoring divider once for the speed, then a multiply
// state and a clamp state before it reaches the done state and pushes the result.
// s_tready is high only while the sequencer is idle; a pending result waits
// in the output register while the next beat is accepted, and the sequencer
// holds its finished result until that register frees.
// Reset (i_rst_n, synchronous) clears the sequencer, the output valid, the
// last capture time and loads both thresholds with their defaults.
module esc_throttle_guard_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [11:0] throttle_in, [27:12] avg_interval_us,
                                   // [59:28] now_ms, [63:60] zero
    input  logic        s_tuser,   // [0] kind
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] throttle_valid, [11:1] throttle_cmd,
                                   // [12] reset_request, [15:13] zero
    // APB config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [esc_tg_pkg::CFG_W-1:0] r_lose;
    logic [esc_tg_pkg::CFG_W-1:0] r_timeout;
    logic                         r_out_valid;
    esc_tg_pkg::t_res             r_out;
    esc_tg_pkg::t_div_req         div_req;
    esc_tg_pkg::t_div_rsp         div_rsp;
    esc_tg_pkg::t_res             res;
    logic                         idle;
    logic                         push;
    logic                         slot_free;
    logic                         s_beat;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register writes; paddr[2] picks the register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lose    <= esc_tg_pkg::LOSE_RESET;
            r_timeout <= esc_tg_pkg::TIMEOUT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                esc_tg_pkg::REG_LOSE:    r_lose    <= pwdata[esc_tg_pkg::CFG_W-1:0];
                esc_tg_pkg::REG_TIMEOUT: r_timeout <= pwdata[esc_tg_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            esc_tg_pkg::REG_LOSE:    prdata = 32'(r_lose);
            esc_tg_pkg::REG_TIMEOUT: prdata = 32'(r_timeout);
            default:                 prdata = '0;
        endcase
    end

    // Accept a beat only while the sequencer is idle
    assign s_tready  = idle;
    assign s_beat    = s_tvalid && s_tready;
    assign slot_free = !r_out_valid || m_tready;

    esc_tg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_beat),
        .i_kind      (s_tuser),
        .i_thr       (s_tdata[11:0]),
        .i_interval  (s_tdata[27:12]),
        .i_now       (s_tdata[59:28]),
        .i_lose      (r_lose),
        .i_timeout   (r_timeout),
        .i_slot_free (slot_free),
        .i_div       (div_rsp),
        .o_div       (div_req),
        .o_idle      (idle),
        .o_push      (push),
        .o_res       (res)
    );

    esc_tg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Output register: load on push, drop valid once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {3'b000, r_out.rst, r_out.cmd, r_out.valid};

endmodule

// ----- sv/esc_tg_chk.sv -----
`timescale 1ns / 1ps

module esc_tg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] i_m_tdata
);

    // busy after every accepted beat
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input accepted on two consecutive cycles");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled result changed");

    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tdata[0] |-> i_m_tdata[12:1] == 12'd0)
        else $error("command or reset request without a valid throttle");

    a_reset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[12] |-> i_m_tdata[0] && i_m_tdata[11:1] == 11'd0)
        else $error("reset request with nonzero throttle");

endmodule

bind esc_throttle_guard_top esc_tg_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_tvalid),
    .i_s_tready (s_tready),
    .i_m_tvalid (m_tvalid),
    .i_m_tready (m_tready),
    .i_m_tdata  (m_tdata)
);
